// ----- hdl/vmm_pkg.sv -----
// Shared types and constants for the 4x4 vector-matrix multiply unit.
// Depends on nothing; vmm_front, vmm_back and the top level import it.
`default_nettype none

package vmm_pkg;

    localparam int DIM       = 4;
    localparam int ELEM_W    = 32;
    localparam int ROW_W     = 2;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * ELEM_W;            // full signed product
    localparam int SHP_W     = PROD_W - FRAC_BITS;    // product after >>> 16
    localparam int PAIR_W    = SHP_W + 1;             // sum of two terms
    localparam int SUM_W     = SHP_W + 2;             // sum of four terms

    // Codes of the action field.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MUL  = 1'b1;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic [ROW_W-1:0]         t_row;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } t_op;

    // Input word as seen on the push side.
    typedef struct packed {
        logic               action;
        t_row               row_index;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
    } t_in_word;

    // Result word as seen on the pop side.
    typedef struct packed {
        t_row               out_row;
        logic signed [31:0] out0;
        logic signed [31:0] out1;
        logic signed [31:0] out2;
        logic signed [31:0] out3;
    } t_out_word;

    // Decoded command passed from the front end to the back end.
    typedef struct packed {
        t_op                 op;
        t_row                row;
        logic [DIM-1:0][ELEM_W-1:0] elems;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hdl/vmm_fifo.sv -----
// Small synchronous FIFO built from registers, generic in word type and depth.
// Depends on nothing; used by the front end and the back end.
`default_nettype none

module vmm_fifo #(
    parameter int  DEPTH  = 4,
    parameter type t_word = logic
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_word i_wdata,
    output logic  o_full,
    input  wire   i_pop,
    output t_word o_rdata,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_word            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/vmm_front.sv -----
// Front end: decode incoming words into load/multiply commands and queue them.
// Depends on vmm_pkg and vmm_fifo.
`default_nettype none

module vmm_front
    import vmm_pkg::*;
#(
    parameter int CMD_DEPTH = 4
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_push,
    input  t_in_word i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  wire      i_cmd_take
);

    t_cmd n_cmd;
    logic cmd_empty;

    // Classify the word and gather the row elements.
    always_comb begin
        n_cmd.row   = i_item.row_index;
        n_cmd.elems = {i_item.elem3, i_item.elem2, i_item.elem1, i_item.elem0};
        unique case (i_item.action)
            ACT_LOAD: n_cmd.op = OP_LOAD;
            ACT_MUL:  n_cmd.op = OP_MUL;
            default:  n_cmd.op = OP_LOAD;
        endcase
    end

    vmm_fifo #(
        .DEPTH  (CMD_DEPTH),
        .t_word (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (n_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_rdata (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ----- hdl/vmm_back.sv -----
// Back end: holds matrix B, runs the multiply pipeline, queues product rows.
// Depends on vmm_pkg and vmm_fifo.
`default_nettype none

module vmm_back
    import vmm_pkg::*;
#(
    parameter int RES_DEPTH = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_empty,
    input  wire       i_pop,
    output t_out_word o_result
);

    localparam int PEND_W = $clog2(RES_DEPTH + 1);

    t_elem                     r_mat_b [DIM][DIM];
    logic                      r_v1;
    t_row                      r_row1;
    logic signed [SHP_W-1:0]   r_shp [DIM][DIM];   // [j][k]
    logic                      r_v2;
    t_row                      r_row2;
    logic signed [PAIR_W-1:0]  r_pair [2][DIM];    // [half][k]
    logic [PEND_W-1:0]         r_pending;

    logic                      issue_mul;
    logic                      res_full;
    logic                      pop_ok;
    logic signed [PROD_W-1:0]  prod [DIM][DIM];
    logic signed [SUM_W-1:0]   fin [DIM];
    t_elem                     sat [DIM];
    t_out_word                 n_res;

    // Loads never produce a result, so take them at once; hold a multiply
    // until the result queue has a slot reserved for it.
    always_comb begin
        o_cmd_take = 1'b0;
        issue_mul  = 1'b0;
        if (i_cmd_valid) begin
            if (i_cmd.op == OP_LOAD) begin
                o_cmd_take = 1'b1;
            end else if (!res_full && r_pending < PEND_W'(RES_DEPTH)) begin
                o_cmd_take = 1'b1;
                issue_mul  = 1'b1;
            end
        end
    end

    // Sixteen products in parallel, one per (j, k).
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            for (int k = 0; k < DIM; k++) begin
                prod[j][k] = PROD_W'($signed(i_cmd.elems[j])) * PROD_W'(r_mat_b[j][k]);
            end
        end
    end

    // Final add and saturate to the signed 32-bit range.
    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            fin[k] = SUM_W'(r_pair[0][k]) + SUM_W'(r_pair[1][k]);
            if (&fin[k][SUM_W-1:ELEM_W-1] || ~|fin[k][SUM_W-1:ELEM_W-1]) begin
                sat[k] = fin[k][ELEM_W-1:0];
            end else if (fin[k][SUM_W-1]) begin
                sat[k] = {1'b1, {(ELEM_W-1){1'b0}}};
            end else begin
                sat[k] = {1'b0, {(ELEM_W-1){1'b1}}};
            end
        end
        n_res.out_row = r_row2;
        n_res.out0    = sat[0];
        n_res.out1    = sat[1];
        n_res.out2    = sat[2];
        n_res.out3    = sat[3];
    end

    // Payload registers: matrix B and pipeline data.
    always_ff @(posedge i_clk) begin
        if (o_cmd_take && i_cmd.op == OP_LOAD) begin
            for (int k = 0; k < DIM; k++) begin
                r_mat_b[i_cmd.row][k] <= $signed(i_cmd.elems[k]);
            end
        end
        if (issue_mul) begin
            r_row1 <= i_cmd.row;
            for (int j = 0; j < DIM; j++) begin
                for (int k = 0; k < DIM; k++) begin
                    // arithmetic shift right by the fraction width = floor
                    r_shp[j][k] <= prod[j][k][PROD_W-1:FRAC_BITS];
                end
            end
        end
        if (r_v1) begin
            r_row2 <= r_row1;
            for (int k = 0; k < DIM; k++) begin
                r_pair[0][k] <= PAIR_W'(r_shp[0][k]) + PAIR_W'(r_shp[1][k]);
                r_pair[1][k] <= PAIR_W'(r_shp[2][k]) + PAIR_W'(r_shp[3][k]);
            end
        end
    end

    assign pop_ok = i_pop && !o_empty;

    // Control: stage valids and the count of reserved result slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_pending <= '0;
        end else begin
            r_v1 <= issue_mul;
            r_v2 <= r_v1;
            case ({issue_mul, pop_ok})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    vmm_fifo #(
        .DEPTH  (RES_DEPTH),
        .t_word (t_out_word)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v2),
        .i_wdata (n_res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

// ----- hdl/vector_matrix_multiply_4x4_unit.sv -----
// Top level of the 4x4 vector-matrix multiply unit (signed Q16.16).
// Depends on vmm_pkg, vmm_front, vmm_back (and vmm_fifo through them).
//
// Usage:
//   Input side is a queue: drive i_item and raise push; the word is taken
//   on a rising edge with push high and full low. action = load writes
//   elem0..3 into row row_index of the stored matrix B and gives no result.
//   action = multiply treats elem0..3 as a row of A and yields one result
//   word: out[k] = sat32(sum_j floor(a[j] * B[j][k] / 2^16)), out_row =
//   row_index. Load a row of B before any multiply that reads it.
//   Result side is a queue: while empty is low, o_result is the oldest
//   product row; it is consumed on an edge with pop high and empty low.
//   A multiply word's result passes the command queue, the product stage and
//   the pair-sum stage. Throughput: one word per cycle unless full, loads and
//   multiplies mixed freely; the sixteen parallel 32x32 multipliers set that
//   figure. Words are processed strictly in order, so a load affects only
//   multiplies accepted after it. When the consumer stalls, up to RES_DEPTH
//   product rows collect in the result queue, then multiplies wait in the
//   command queue and full rises. Reset empties both queues and the pipeline;
//   matrix B is not cleared.
`default_nettype none

module vector_matrix_multiply_4x4_unit
    import vmm_pkg::*;
#(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       push,
    input  t_in_word  i_item,
    output logic      full,
    output logic      empty,
    input  wire       pop,
    output t_out_word o_result
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    // Front end: classify and queue words.
    vmm_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Back end: apply loads, multiply rows, hold results until popped.
    vmm_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
